[sv/lltr_pkg.sv]
// ----------------------------------------------------------------------------
// lltr_pkg
// Shared types, constants and codes of the table-driven predictive recognizer.
// ----------------------------------------------------------------------------
package lltr_pkg;

	localparam int StackDepth = 64;
	localparam int NumNonterminals = 16;
	localparam int NumProductions = 64;
	localparam int MaxBodyLen = 8;

	localparam int SpW = 7;
	localparam int SpIdxW = 6;
	localparam int ProdW = 6;
	localparam int PosW = 3;
	localparam int LenW = 4;
	localparam int SymW = 9;
	localparam int TabAddrW = 12;

	localparam logic [7:0] END_MARK = 8'h23;
	localparam logic [7:0] EPS_MARK = 8'h40;

	typedef enum logic [2:0] {
		CMD_TABLE = 3'd0,
		CMD_PSYM = 3'd1,
		CMD_PLEN = 3'd2,
		CMD_START = 3'd3,
		CMD_TOKEN = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_REJECT = 3'd1,
		ST_ACCEPT = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	localparam logic CFG_START_NT = 1'b0;
	localparam logic CFG_EXPAND_LIMIT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_WRITE,
		S_FETCH,
		S_LOOK,
		S_DECIDE,
		S_LEN,
		S_PUSH,
		S_DONE,
		S_RESULT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic clear_step;
		logic do_write;
		logic do_start;
		logic load_tok;
		logic sel_end;
		logic read_top;
		logic read_tab;
		logic pop;
		logic expand;
		logic push_sym;
		logic finish;
		logic [2:0] fin_status;
	} ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic clear_done;
		logic sp_empty;
		logic top_nt;
		logic top_eps;
		logic top_match;
		logic entry_ok;
		logic limit_hit;
		logic overflow;
		logic push_done;
	} sts_t;

endpackage

[sv/lltr_datapath.sv]
// ----------------------------------------------------------------------------
// lltr_datapath
// Parse stack, prediction table, production store and result register.
// ----------------------------------------------------------------------------
module lltr_datapath import lltr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	output sts_t sts,
	input  logic [2:0] cmd,
	input  logic [3:0] nonterminal,
	input  logic [7:0] terminal,
	input  logic [5:0] prod_index,
	input  logic entry_valid,
	input  logic [2:0] position,
	input  logic symbol_kind,
	input  logic [7:0] symbol_value,
	input  logic [3:0] prod_length,
	input  logic [3:0] start_nt,
	input  logic [7:0] expand_limit,
	output logic [2:0] status,
	output logic [6:0] stack_depth
);

	logic [SymW-1:0] stack_mem [StackDepth];
	logic [6:0] table_mem [1 << TabAddrW];
	logic [SymW-1:0] psym_mem [NumProductions * MaxBodyLen];
	logic [LenW-1:0] plen_mem [NumProductions];

	logic [SpW-1:0] sp_q;
	logic [TabAddrW-1:0] clr_q;
	logic [7:0] tok_q;
	logic [7:0] exp_cnt_q;
	logic [SymW-1:0] top_q;
	logic [6:0] entry_q;
	logic [LenW-1:0] left_q;
	logic [ProdW-1:0] prod_q;
	logic [SymW-1:0] psym_q;
	logic [2:0] status_q;

	logic [TabAddrW-1:0] tab_raddr;
	logic [8:0] psym_raddr;
	logic [PosW-1:0] slot;
	logic [SpW:0] new_sp;
	logic [LenW-1:0] clamp_len;

	assign tab_raddr = {top_q[3:0], tok_q};
	// While pushing, fetch the preceding body symbol, which is pushed next.
	assign slot = ctl.push_sym ? PosW'(left_q - LenW'(2)) : PosW'(left_q - LenW'(1));
	assign psym_raddr = {prod_q, slot};
	assign new_sp = {1'b0, sp_q} + {4'd0, left_q};
	assign clamp_len = (prod_length > LenW'(MaxBodyLen)) ? LenW'(MaxBodyLen) : prod_length;

	// Clearing pass and table writes share the single write port.
	always_ff @(posedge clk) begin
		if (ctl.clear_step) begin
			table_mem[clr_q] <= '0;
		end else if (ctl.do_write && cmd == CMD_TABLE) begin
			table_mem[{nonterminal, terminal}] <= entry_valid ? {1'b1, prod_index} : 7'd0;
		end
		if (ctl.read_tab) begin
			entry_q <= table_mem[tab_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_write && cmd == CMD_PSYM) begin
			psym_mem[{prod_index, position}] <= {symbol_kind, symbol_value};
		end
		if (ctl.do_write && cmd == CMD_PLEN) begin
			plen_mem[prod_index] <= clamp_len;
		end
		psym_q <= psym_mem[psym_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.do_start) begin
			stack_mem[0] <= {1'b0, END_MARK};
			stack_mem[1] <= {1'b1, 4'd0, start_nt};
		end else if (ctl.push_sym) begin
			stack_mem[sp_q[SpIdxW-1:0]] <= psym_q;
		end
		if (ctl.read_top) begin
			top_q <= stack_mem[SpIdxW'(sp_q - SpW'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			clr_q <= '0;
			tok_q <= '0;
			exp_cnt_q <= '0;
			left_q <= '0;
			prod_q <= '0;
			status_q <= '0;
		end else begin
			if (ctl.clear_step) begin
				clr_q <= clr_q + TabAddrW'(1);
			end
			if (ctl.do_start) begin
				sp_q <= SpW'(2);
			end
			if (ctl.load_tok) begin
				tok_q <= ctl.sel_end ? END_MARK : terminal;
				exp_cnt_q <= '0;
			end
			if (ctl.pop) begin
				sp_q <= sp_q - SpW'(1);
			end
			if (ctl.expand) begin
				exp_cnt_q <= exp_cnt_q + 8'd1;
				sp_q <= sp_q - SpW'(1);
				prod_q <= entry_q[5:0];
				left_q <= plen_mem[entry_q[5:0]];
			end
			if (ctl.push_sym) begin
				sp_q <= sp_q + SpW'(1);
				left_q <= left_q - LenW'(1);
			end
			if (ctl.finish) begin
				status_q <= ctl.fin_status;
			end
		end
	end

	always_comb begin
		sts.clear_done = (clr_q == '1);
		sts.sp_empty = (sp_q == '0);
		sts.top_nt = top_q[8];
		sts.top_eps = (top_q[7:0] == EPS_MARK);
		sts.top_match = (top_q[7:0] == tok_q);
		sts.entry_ok = (top_q[7:4] == 4'd0) && entry_q[6];
		sts.limit_hit = (exp_cnt_q >= expand_limit);
		sts.overflow = (new_sp > 8'(StackDepth));
		sts.push_done = (left_q == '0);
	end

	assign status = status_q;
	assign stack_depth = sp_q;

endmodule

[sv/lltr_controller.sv]
// ----------------------------------------------------------------------------
// lltr_controller
// Sequencer for writes, starts and the expand / match loop of each token.
// ----------------------------------------------------------------------------
module lltr_controller import lltr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  logic [2:0] cmd,
	input  logic [7:0] terminal,
	input  logic last_token,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic active_q, active_d;
	logic end_q, end_d;
	logic last_q;
	logic [2:0] fst;
	logic fin_en;
	logic go;

	assign go = in_valid && in_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		active_d = active_q;
		end_d = end_q;
		fst = ST_OK;
		fin_en = 1'b0;
		case (state_q)
			S_CLEAR: begin
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (go) begin
					fin_en = 1'b1;
					state_d = S_RESULT;
					case (cmd)
						CMD_TABLE, CMD_PSYM, CMD_PLEN: fst = ST_OK;
						CMD_START: begin
							fst = ST_OK;
							active_d = 1'b1;
						end
						CMD_TOKEN: begin
							if (!active_q) begin
								fst = ST_IGNORED;
							end else if (terminal == EPS_MARK) begin
								if (last_token) begin
									fin_en = 1'b0;
									end_d = 1'b1;
									state_d = S_FETCH;
								end
							end else begin
								fin_en = 1'b0;
								end_d = 1'b0;
								state_d = S_FETCH;
							end
						end
						default: fst = ST_IGNORED;
					endcase
				end
			end
			S_FETCH: state_d = S_LOOK;
			S_LOOK: state_d = S_DECIDE;
			S_DECIDE: begin
				if (sts.sp_empty) begin
					fst = ST_REJECT;
					fin_en = 1'b1;
				end else if (!sts.top_nt) begin
					if (sts.top_eps) begin
						state_d = S_FETCH;
					end else if (!sts.top_match) begin
						fst = ST_REJECT;
						fin_en = 1'b1;
					end else begin
						state_d = S_DONE;
					end
				end else if (!sts.entry_ok || sts.limit_hit) begin
					fst = ST_REJECT;
					fin_en = 1'b1;
				end else begin
					state_d = S_LEN;
				end
				if (fin_en) begin
					active_d = 1'b0;
					state_d = S_RESULT;
				end
			end
			S_LEN: begin
				// The body length is now registered; the nonterminal is already popped.
				if (sts.overflow) begin
					fst = ST_OVERFLOW;
					fin_en = 1'b1;
					active_d = 1'b0;
					state_d = S_RESULT;
				end else begin
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				if (sts.push_done) begin
					state_d = S_FETCH;
				end
			end
			S_DONE: begin
				// Match popped the terminal in the previous cycle.
				if (last_q && !end_q) begin
					end_d = 1'b1;
					state_d = S_FETCH;
				end else begin
					fin_en = 1'b1;
					state_d = S_RESULT;
					if (end_q) begin
						fst = sts.sp_empty ? ST_ACCEPT : ST_REJECT;
						active_d = 1'b0;
					end
				end
			end
			S_RESULT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		ctl = '0;
		ctl.fin_status = fst;
		ctl.finish = fin_en;
		case (state_q)
			S_CLEAR: ctl.clear_step = 1'b1;
			S_IDLE: begin
				ctl.do_write = go;
				ctl.do_start = go && cmd == CMD_START;
				ctl.load_tok = go && cmd == CMD_TOKEN;
				ctl.sel_end = terminal == EPS_MARK;
			end
			S_FETCH: ctl.read_top = 1'b1;
			S_LOOK: ctl.read_tab = 1'b1;
			S_DECIDE: begin
				ctl.pop = !sts.sp_empty && !sts.top_nt && (sts.top_eps || sts.top_match);
				ctl.expand = state_d == S_LEN;
			end
			S_PUSH: ctl.push_sym = !sts.push_done;
			S_DONE: begin
				ctl.load_tok = last_q && !end_q;
				ctl.sel_end = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			active_q <= 1'b0;
			end_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			active_q <= active_d;
			end_q <= end_d;
			if (go) begin
				last_q <= last_token;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_RESULT);

endmodule

[sv/ll1_table_driven_recognizer_core.sv]
// ----------------------------------------------------------------------------
// ll1_table_driven_recognizer_core
// Table-driven predictive recognizer with loadable table and productions.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-entry prediction table clear, one
// entry a cycle, and takes no item until that pass is done.
// Each accepted item gives exactly one result transfer. Table, production and
// start items go straight to the result state, which holds the output
// transfer until it is taken. A token runs a fetch, table look-up and decide
// loop for every stack symbol it examines, and a matched terminal adds a done
// state to close the item. An expansion adds a length state that checks the
// registered production length for overflow, then a push state that writes
// one symbol a cycle and leaves once all are pushed. A last token adds the
// same loop once more for the end marker.
module ll1_table_driven_recognizer_core import lltr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [2:0] cmd,
	input  logic [3:0] nonterminal,
	input  logic [7:0] terminal,
	input  logic [5:0] prod_index,
	input  logic entry_valid,
	input  logic [2:0] position,
	input  logic symbol_kind,
	input  logic [7:0] symbol_value,
	input  logic [3:0] prod_length,
	input  logic last_token,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] status,
	output logic [6:0] stack_depth
);

	logic [3:0] start_nt_q;
	logic [7:0] expand_limit_q;
	ctl_t ctl;
	sts_t sts;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_nt_q <= '0;
			expand_limit_q <= 8'd64;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START_NT) begin
				start_nt_q <= cfg_data[3:0];
			end else begin
				expand_limit_q <= cfg_data;
			end
		end
	end

	lltr_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd),
		.terminal(terminal), .last_token(last_token), .sts(sts), .ctl(ctl)
	);

	lltr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .cmd(cmd),
		.nonterminal(nonterminal), .terminal(terminal), .prod_index(prod_index),
		.entry_valid(entry_valid), .position(position), .symbol_kind(symbol_kind),
		.symbol_value(symbol_value), .prod_length(prod_length),
		.start_nt(start_nt_q), .expand_limit(expand_limit_q),
		.status(status), .stack_depth(stack_depth)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the table-driven predictive recognizer: random
// grammars are loaded, sentences are fed as tokens, and every result is
// compared with an in-bench prediction of the parse.
// ----------------------------------------------------------------------------
module tb;
	import lltr_pkg::*;

	localparam int CycleLimit = 20000000;
	localparam int MaxWait = 17;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int ItemGoal = 1800;

	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] nt;
		logic [7:0] term;
		logic [5:0] prod;
		logic ev;
		logic [2:0] pos;
		logic kind;
		logic [7:0] sval;
		logic [3:0] plen;
		logic last;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] depth;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = CFG_START_NT;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [6:0] stack_depth;
	item_t cur = '0;

	// The bench's own picture of the recognizer state.
	logic [8:0] stk[StackDepth];
	int sp = 0;
	logic [6:0] ptab[NumNonterminals * 256];
	logic [8:0] body[NumProductions * MaxBodyLen];
	logic [3:0] blen[NumProductions];
	logic parsing = 1'b0;
	logic [3:0] start_nt = 4'd0;
	logic [7:0] exp_limit = 8'd64;

	// What the stimulus has loaded so far, so no unwritten body is ever used.
	bit sym_ok[NumProductions][MaxBodyLen];
	bit len_ok[NumProductions];

	item_t pending[$];
	outcome_t outcomes[$];
	int errs = 0;
	int cycles = 0;
	int gap = 0;
	int stall = 0;
	bit quiet = 0;
	int made = 0;

	ll1_table_driven_recognizer_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cur.cmd), .nonterminal(cur.nt), .terminal(cur.term),
		.prod_index(cur.prod), .entry_valid(cur.ev), .position(cur.pos),
		.symbol_kind(cur.kind), .symbol_value(cur.sval),
		.prod_length(cur.plen), .last_token(cur.last),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .stack_depth(stack_depth)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int wait_draw();
		if (quiet)
			return 0;
		return $urandom_range(0, MaxWait);
	endfunction

	// Runs one terminal (a token or the end marker) against the stack.
	function automatic status_t drive_terminal(logic [7:0] tok);
		int n;
		logic [8:0] top;
		logic [6:0] ent;
		int len;
		n = 0;
		forever begin
			if (sp == 0)
				return ST_REJECT;
			top = stk[sp - 1];
			if (!top[8]) begin
				if (top[7:0] == EPS_MARK) begin
					sp--;
					continue;
				end
				if (top[7:0] != tok)
					return ST_REJECT;
				sp--;
				return ST_OK;
			end
			if (top[7:0] >= NumNonterminals)
				return ST_REJECT;
			ent = ptab[{top[3:0], tok}];
			if (!ent[6])
				return ST_REJECT;
			if (n >= exp_limit)
				return ST_REJECT;
			n++;
			len = blen[ent[5:0]];
			sp--;
			if (sp + len > StackDepth)
				return ST_OVERFLOW;
			for (int i = len; i > 0; i--) begin
				stk[sp] = body[ent[5:0] * MaxBodyLen + i - 1];
				sp++;
			end
		end
	endfunction

	// Applies one accepted item and returns the result it must produce.
	function automatic outcome_t parse_item(item_t it);
		status_t st;
		outcome_t o;
		st = ST_OK;
		case (it.cmd)
			CMD_TABLE: ptab[{it.nt, it.term}] = it.ev ? {1'b1, it.prod} : 7'd0;
			CMD_PSYM: body[it.prod * MaxBodyLen + it.pos] = {it.kind, it.sval};
			CMD_PLEN: blen[it.prod] = (it.plen > MaxBodyLen) ? LenW'(MaxBodyLen) : it.plen;
			CMD_START: begin
				stk[0] = {1'b0, END_MARK};
				stk[1] = {1'b1, 4'd0, start_nt};
				sp = 2;
				parsing = 1'b1;
			end
			CMD_TOKEN: begin
				if (!parsing) begin
					st = ST_IGNORED;
				end else begin
					if (it.term != EPS_MARK)
						st = drive_terminal(it.term);
					if (st == ST_OK && it.last) begin
						st = drive_terminal(END_MARK);
						if (st == ST_OK)
							st = (sp == 0) ? ST_ACCEPT : ST_REJECT;
					end
					if (st != ST_OK)
						parsing = 1'b0;
				end
			end
			default: st = ST_IGNORED;
		endcase
		o.status = st;
		o.depth = sp[6:0];
		return o;
	endfunction

	// The driver: one transfer per handshake, a random gap before each item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap <= 0;
		end else begin
			if (in_valid && in_ready)
				outcomes.push_back(parse_item(cur));
			if (!(in_valid && !in_ready)) begin
				if (gap > 0) begin
					gap <= gap - 1;
					in_valid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur <= pending.pop_front();
					in_valid <= 1'b1;
					gap <= wait_draw();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The monitor: random back-pressure, each result checked in order.
	always @(posedge clk or negedge arst_n) begin
		int nxt;
		outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall <= 0;
		end else if (out_valid && out_ready) begin
			if (outcomes.size() == 0) begin
				$display("%0t: result with nothing expected, status %0d depth %0d",
					$time, status, stack_depth);
				errs++;
			end else begin
				want = outcomes.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					errs++;
				end
				if (stack_depth !== want.depth) begin
					$display("%0t: stack_depth expected %0d actual %0d",
						$time, want.depth, stack_depth);
					errs++;
				end
			end
			nxt = wait_draw();
			stall <= nxt;
			out_ready <= (nxt == 0);
		end else if (stall > 0) begin
			stall <= stall - 1;
			out_ready <= (stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic put(item_t it);
		pending.push_back(it);
		if (it.cmd <= CMD_TOKEN)
			made++;
	endtask

	task automatic put_entry(logic [3:0] nt, logic [7:0] t, logic [5:0] p, logic ev);
		item_t it;
		it = item_t'($urandom());
		it.cmd = CMD_TABLE;
		it.nt = nt;
		it.term = t;
		it.prod = p;
		it.ev = ev;
		put(it);
	endtask

	task automatic put_sym(logic [5:0] p, int pos, logic kind, logic [7:0] v);
		item_t it;
		it = item_t'($urandom());
		it.cmd = CMD_PSYM;
		it.prod = p;
		it.pos = pos[2:0];
		it.kind = kind;
		it.sval = v;
		sym_ok[p][pos] = 1;
		put(it);
	endtask

	// Writes a length, first filling any slot it covers that was never loaded.
	task automatic put_len(logic [5:0] p, logic [3:0] len);
		item_t it;
		for (int i = 0; i < len && i < MaxBodyLen; i++)
			if (!sym_ok[p][i])
				put_sym(p, i, 1'b0, 8'($urandom()));
		it = item_t'($urandom());
		it.cmd = CMD_PLEN;
		it.prod = p;
		it.plen = len;
		len_ok[p] = 1;
		put(it);
	endtask

	task automatic put_start();
		item_t it;
		it = item_t'($urandom());
		it.cmd = CMD_START;
		put(it);
	endtask

	task automatic put_tok(logic [7:0] t, logic last);
		item_t it;
		it = item_t'($urandom());
		it.cmd = CMD_TOKEN;
		it.term = t;
		it.last = last;
		put(it);
	endtask

	task automatic put_spare(logic [2:0] c);
		item_t it;
		it = item_t'($urandom());
		it.cmd = c;
		put(it);
	endtask

	// Sampled away from the active edge so the driver's updates have settled.
	task automatic drain();
		while (pending.size() > 0 || in_valid || outcomes.size() > 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == CFG_START_NT)
			start_nt = v[3:0];
		else
			exp_limit = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Loads a random grammar over a few nonterminals and a small alphabet,
	// then feeds sentences. Most productions are right-linear so that many
	// sentences get deep into the parse; some carry epsilons, stray
	// terminals, bad nonterminal indexes or left recursion.
	task automatic grammar_phase(int phase);
		int k;
		int base;
		logic [7:0] alpha[3];
		logic [3:0] nts[6];
		logic [5:0] p;
		int len;
		int r;
		int ntok;
		logic [7:0] t;
		k = $urandom_range(2, 6);
		base = $urandom_range(0, 15);
		for (int i = 0; i < k; i++)
			nts[i] = 4'((base + i) % NumNonterminals);
		for (int j = 0; j < 3; j++)
			alpha[j] = 8'($urandom());

		drain();
		if (phase % 5 == 0)
			write_reg(CFG_EXPAND_LIMIT, 8'd1);
		else if (phase % 5 == 1)
			write_reg(CFG_EXPAND_LIMIT, 8'd255);
		else
			write_reg(CFG_EXPAND_LIMIT, 8'($urandom_range(2, 80)));
		write_reg(CFG_START_NT, ($urandom_range(0, 9) == 0) ? 8'($urandom()) : {4'd0, nts[0]});
		quiet = (phase % 4 == 3);

		for (int i = 0; i < k; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ($urandom_range(0, 9) < 8) begin
					p = 6'($urandom());
					r = $urandom_range(0, 99);
					len = 0;
					if (r < 5) begin
						put_sym(p, 0, 1'b1, {4'd0, nts[i]});
						put_sym(p, 1, 1'b0, alpha[j]);
						len = 2;
					end else if (r < 9) begin
						for (int s = 0; s < MaxBodyLen; s++)
							put_sym(p, s, 1'($urandom()), 8'($urandom()));
						len = $urandom_range(MaxBodyLen, 15);
					end else begin
						if ($urandom_range(0, 9) == 0) begin
							put_sym(p, len, 1'b0, EPS_MARK);
							len++;
						end
						put_sym(p, len, 1'b0, alpha[j]);
						len++;
						if ($urandom_range(0, 9) == 0) begin
							put_sym(p, len, 1'b0, alpha[$urandom_range(0, 2)]);
							len++;
						end
						if ($urandom_range(0, 9) < 7) begin
							put_sym(p, len, 1'b1, ($urandom_range(0, 19) == 0) ?
								8'($urandom()) : {4'd0, nts[$urandom_range(0, k - 1)]});
							len++;
						end
					end
					put_len(p, 4'(len));
					put_entry(nts[i], alpha[j], p, 1'b1);
				end else if ($urandom_range(0, 1) == 0) begin
					put_entry(nts[i], alpha[j], 6'($urandom()), 1'b0);
				end
			end
			if ($urandom_range(0, 9) < 8) begin
				p = 6'($urandom());
				put_len(p, 4'd0);
				put_entry(nts[i], END_MARK, p, 1'b1);
			end
		end

		for (int s = $urandom_range(4, 10); s > 0; s--) begin
			put_start();
			ntok = $urandom_range(1, 12);
			for (int n = 0; n < ntok; n++) begin
				r = $urandom_range(0, 99);
				if (r < 90)
					t = alpha[$urandom_range(0, 2)];
				else if (r < 95)
					t = EPS_MARK;
				else
					t = 8'($urandom());
				put_tok(t, (n == ntok - 1) && ($urandom_range(0, 9) != 0));
			end
			if ($urandom_range(0, 19) == 0)
				put_spare(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
		end
	endtask

	initial begin
		int phase;
		for (int i = 0; i < NumNonterminals * 256; i++)
			ptab[i] = 7'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: idle tokens, spare commands, then a tiny grammar
		// where S = a A and A = @ b | epsilon on the end marker.
		write_reg(CFG_START_NT, 8'd0);
		write_reg(CFG_EXPAND_LIMIT, 8'd64);
		put_tok("a", 1'b0);
		put_spare(CMD_SPARE_LO);
		put_spare(CMD_SPARE_HI);
		put_sym(6'd0, 0, 1'b0, "a");
		put_sym(6'd0, 1, 1'b1, 8'd1);
		put_len(6'd0, 4'd2);
		put_len(6'd1, 4'd0);
		put_sym(6'd2, 0, 1'b0, EPS_MARK);
		put_sym(6'd2, 1, 1'b0, "b");
		put_len(6'd2, 4'd2);
		put_entry(4'd0, "a", 6'd0, 1'b1);
		put_entry(4'd1, END_MARK, 6'd1, 1'b1);
		put_entry(4'd1, "b", 6'd2, 1'b1);
		put_start();
		put_tok("a", 1'b0);
		put_tok(EPS_MARK, 1'b0);
		put_tok("b", 1'b1);
		put_start();
		put_tok("a", 1'b1);
		put_start();
		put_tok("z", 1'b0);
		put_tok("a", 1'b0);
		put_start();
		put_tok(EPS_MARK, 1'b1);
		put_entry(4'd15, 8'hff, 6'd63, 1'b0);

		phase = 0;
		while (made < ItemGoal) begin
			grammar_phase(phase);
			phase++;
		end

		drain();
		repeat (50) @(posedge clk);
		if (errs == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
